[hw/rtl/ppmd_pkg.sv]
// ----------------------------------------------------------------------------
// ppmd_pkg
// Shared types and constants of the PPM frame decoder: field widths, register
// indexes, register reset values and the width-memory write command.
// ----------------------------------------------------------------------------
package ppmd_pkg;

	localparam int TIME_W     = 32;
	localparam int GAP_W      = 16;
	localparam int FRAME_GAP_W = 15;
	localparam int PULSE_W    = 12;
	localparam int CH_IDX_W   = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 15;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_GAP = 2'd0,
		REG_PULSE_MIN = 2'd1,
		REG_PULSE_MAX = 2'd2
	} reg_idx_t;

	localparam logic [FRAME_GAP_W-1:0] FRAME_GAP_RST = 15'd2500;
	localparam logic [PULSE_W-1:0]     PULSE_MIN_RST = 12'd800;
	localparam logic [PULSE_W-1:0]     PULSE_MAX_RST = 12'd2200;

	typedef struct packed {
		logic [FRAME_GAP_W-1:0] frame_gap_us;
		logic [PULSE_W-1:0]     pulse_min_us;
		logic [PULSE_W-1:0]     pulse_max_us;
	} cfg_t;

	typedef struct packed {
		logic                en;
		logic [CH_IDX_W-1:0] addr;
		logic [PULSE_W-1:0]  data;
	} wr_cmd_t;

endpackage

[hw/rtl/ppmd_if.sv]
// ----------------------------------------------------------------------------
// ppmd_in_if / ppmd_out_if
// Valid/ready channels of the PPM frame decoder: edge and read items in,
// per-channel width results out.
// ----------------------------------------------------------------------------
interface ppmd_in_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [31:0] edge_time_us;

	modport source (output valid, output mode, output edge_time_us, input ready);
	modport sink   (input valid, input mode, input edge_time_us, output ready);
endinterface

interface ppmd_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  channel_index;
	logic [11:0] channel_width_us;
	logic        fresh_flag;
	logic        last_of_run;

	modport source (output valid, output channel_index, output channel_width_us,
		output fresh_flag, output last_of_run, input ready);
	modport sink   (input valid, input channel_index, input channel_width_us,
		input fresh_flag, input last_of_run, output ready);
endinterface

[hw/rtl/ppmd_ram.sv]
// ----------------------------------------------------------------------------
// ppmd_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ppmd_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 8
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hw/rtl/ppmd_edge.sv]
// ----------------------------------------------------------------------------
// ppmd_edge
// Edge timing: gap since the previous edge, frame sync, channel position,
// frame-good and fresh flags, and width-memory writes with entry valid bits.
// ----------------------------------------------------------------------------
module ppmd_edge import ppmd_pkg::*; #(
	parameter int CHANNELS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	input  logic                edge_acc,
	input  logic [TIME_W-1:0]   edge_time_us,
	input  logic                clear_fresh,
	output wr_cmd_t             wr,
	output logic                fresh,
	output logic [CHANNELS-1:0] entry_valid
);

	localparam int IDX_W = CHANNELS > 1 ? $clog2(CHANNELS) : 1;
	localparam int POS_W = $clog2(CHANNELS + 1);

	logic [GAP_W-1:0]  prev_q;
	logic [POS_W-1:0]  pos_q;
	logic              good_q;
	logic              fresh_q;
	logic [CHANNELS-1:0] valid_q;

	logic signed [GAP_W-1:0] gap;
	logic                    is_sync;
	logic                    has_room;
	logic                    in_range;

	// only the low bits of the time difference matter
	assign gap      = $signed(edge_time_us[GAP_W-1:0] - prev_q);
	assign is_sync  = gap > $signed({1'b0, cfg.frame_gap_us});
	assign has_room = pos_q < POS_W'(CHANNELS);
	assign in_range = (gap >= $signed({4'b0, cfg.pulse_min_us}))
		&& (gap <= $signed({4'b0, cfg.pulse_max_us}));

	always_comb begin
		wr.en   = edge_acc && !is_sync && has_room && in_range;
		wr.addr = CH_IDX_W'(pos_q[IDX_W-1:0]);
		wr.data = gap[PULSE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			pos_q   <= '0;
			good_q  <= 1'b0;
			fresh_q <= 1'b0;
			valid_q <= '0;
		end else begin
			if (clear_fresh) begin
				fresh_q <= 1'b0;
			end
			if (edge_acc) begin
				prev_q <= edge_time_us[GAP_W-1:0];
				if (is_sync) begin
					fresh_q <= good_q;
					good_q  <= 1'b1;
					pos_q   <= '0;
				end else if (has_room) begin
					if (in_range) begin
						valid_q[pos_q[IDX_W-1:0]] <= 1'b1;
					end else begin
						good_q <= 1'b0;
					end
					pos_q <= pos_q + POS_W'(1);
				end
			end
		end
	end

	assign fresh       = fresh_q;
	assign entry_valid = valid_q;

endmodule

[hw/rtl/ppmd_reader.sv]
// ----------------------------------------------------------------------------
// ppmd_reader
// Read sweep: walks the width memory one channel at a time and drives the
// result channel through an output register.
// ----------------------------------------------------------------------------
module ppmd_reader import ppmd_pkg::*; #(
	parameter int CHANNELS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                fresh,
	input  logic [CHANNELS-1:0] entry_valid,
	output logic                busy,
	output logic                rd_en,
	output logic [(CHANNELS > 1 ? $clog2(CHANNELS) : 1)-1:0] rd_addr,
	input  logic [PULSE_W-1:0]  rd_data,
	ppmd_out_if.source          out_ch
);

	localparam int IDX_W = CHANNELS > 1 ? $clog2(CHANNELS) : 1;

	typedef enum logic {
		RD_IDLE,
		RD_SWEEP
	} state_t;

	state_t              state_q;
	logic [IDX_W-1:0]    addr_q;
	logic                fresh_q;
	logic                pend_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic                vld_s1;
	logic                last_s1;
	logic                out_valid_q;
	logic [CH_IDX_W-1:0] out_idx_q;
	logic [PULSE_W-1:0]  out_width_q;
	logic                out_fresh_q;
	logic                out_last_q;
	logic                is_last;

	// issue only when the output register is sure to be free as data lands
	assign rd_en   = (state_q == RD_SWEEP) && !pend_s1 && (!out_valid_q || out_ch.ready);
	assign rd_addr = addr_q;
	assign is_last = addr_q == IDX_W'(CHANNELS - 1);
	assign busy    = state_q == RD_SWEEP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= RD_IDLE;
			addr_q      <= '0;
			fresh_q     <= 1'b0;
			pend_s1     <= 1'b0;
			idx_s1      <= '0;
			vld_s1      <= 1'b0;
			last_s1     <= 1'b0;
			out_valid_q <= 1'b0;
			out_idx_q   <= '0;
			out_width_q <= '0;
			out_fresh_q <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			pend_s1 <= rd_en;
			case (state_q)
				RD_IDLE: begin
					if (start) begin
						state_q <= RD_SWEEP;
						addr_q  <= '0;
						fresh_q <= fresh;
					end
				end
				RD_SWEEP: begin
					if (rd_en) begin
						idx_s1  <= addr_q;
						vld_s1  <= entry_valid[addr_q];
						last_s1 <= is_last;
						if (is_last) begin
							state_q <= RD_IDLE;
						end else begin
							addr_q <= addr_q + IDX_W'(1);
						end
					end
				end
				default: state_q <= RD_IDLE;
			endcase
			if (pend_s1) begin
				out_valid_q <= 1'b1;
				out_idx_q   <= CH_IDX_W'(idx_s1);
				out_width_q <= vld_s1 ? rd_data : '0;
				out_fresh_q <= fresh_q;
				out_last_q  <= last_s1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_ch.valid            = out_valid_q;
	assign out_ch.channel_index    = out_idx_q;
	assign out_ch.channel_width_us = out_width_q;
	assign out_ch.fresh_flag       = out_fresh_q;
	assign out_ch.last_of_run      = out_last_q;

endmodule

[hw/rtl/ppm_frame_decoder.sv]
// ----------------------------------------------------------------------------
// ppm_frame_decoder
// Combined-PPM frame decoder driven by edge timestamps.
// ----------------------------------------------------------------------------
// An edge item (mode 0) is taken while no read is in progress: the gap to
// the previous edge is checked against the frame gap and the pulse window,
// and a valid width is written to the width memory in the same cycle. A
// read item (mode 1) emits CHANNELS results; each goes through the width
// memory's registered read before reaching the output register, and the
// next address waits until that read has landed. The next item is taken
// once the last channel address has been issued. Channels never written
// since reset report width zero. Configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module ppm_frame_decoder import ppmd_pkg::*; #(
	parameter int CHANNELS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	ppmd_in_if.sink               in_ch,
	ppmd_out_if.source            out_ch
);

	localparam int IDX_W = CHANNELS > 1 ? $clog2(CHANNELS) : 1;

	cfg_t                cfg_q;
	wr_cmd_t             wr;
	logic                fresh;
	logic [CHANNELS-1:0] entry_valid;
	logic                busy;
	logic                rd_en;
	logic [IDX_W-1:0]    rd_addr;
	logic [PULSE_W-1:0]  rd_data;
	logic                in_acc;
	logic                edge_acc;
	logic                read_acc;

	assign in_ch.ready = !busy;
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign edge_acc    = in_acc && !in_ch.mode;
	assign read_acc    = in_acc && in_ch.mode;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_gap_us <= FRAME_GAP_RST;
			cfg_q.pulse_min_us <= PULSE_MIN_RST;
			cfg_q.pulse_max_us <= PULSE_MAX_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_GAP: cfg_q.frame_gap_us <= cfg_data[FRAME_GAP_W-1:0];
				REG_PULSE_MIN: cfg_q.pulse_min_us <= cfg_data[PULSE_W-1:0];
				REG_PULSE_MAX: cfg_q.pulse_max_us <= cfg_data[PULSE_W-1:0];
				default: ; // drop writes to unknown registers
			endcase
		end
	end

	ppmd_edge #(.CHANNELS(CHANNELS)) u_edge (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.edge_acc     (edge_acc),
		.edge_time_us (in_ch.edge_time_us),
		.clear_fresh  (read_acc),
		.wr           (wr),
		.fresh        (fresh),
		.entry_valid  (entry_valid)
	);

	ppmd_ram #(.WIDTH(PULSE_W), .DEPTH(CHANNELS)) u_widths (
		.clk   (clk),
		.we    (wr.en),
		.waddr (wr.addr[IDX_W-1:0]),
		.wdata (wr.data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	ppmd_reader #(.CHANNELS(CHANNELS)) u_reader (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (read_acc),
		.fresh       (fresh),
		.entry_valid (entry_valid),
		.busy        (busy),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.rd_data     (rd_data),
		.out_ch      (out_ch)
	);

endmodule

[hw/rtl/ppmd_checker.sv]
// ----------------------------------------------------------------------------
// ppmd_checker
// Port-level checks of the PPM frame decoder: result ordering and fresh flag
// within a read and result channel handshake, bound to the top level.
// ----------------------------------------------------------------------------
module ppmd_checker import ppmd_pkg::*; #(
	parameter int CHANNELS = 8
) (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_ready,
	input logic [CH_IDX_W-1:0] channel_index,
	input logic                fresh_flag,
	input logic                last_of_run
);

	logic [CH_IDX_W-1:0] exp_idx_q;
	logic                run_fresh_q;
	logic                out_acc;

	assign out_acc = out_valid && out_ready;

	// track the channel expected next and the fresh flag of the current run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_idx_q   <= '0;
			run_fresh_q <= 1'b0;
		end else if (out_acc) begin
			if (last_of_run) begin
				exp_idx_q <= '0;
			end else begin
				exp_idx_q <= exp_idx_q + CH_IDX_W'(1);
			end
			if (exp_idx_q == '0) begin
				run_fresh_q <= fresh_flag;
			end
		end
	end

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result valid dropped while stalled");

	a_index_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> channel_index == exp_idx_q)
		else $error("result channel out of order");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> last_of_run == (channel_index == CH_IDX_W'(CHANNELS - 1)))
		else $error("last_of_run not on final channel");

	a_fresh_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && exp_idx_q != '0 |-> fresh_flag == run_fresh_q)
		else $error("fresh flag changed within a read");

endmodule

bind ppm_frame_decoder ppmd_checker #(.CHANNELS(CHANNELS)) u_ppmd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.channel_index (out_ch.channel_index),
	.fresh_flag    (out_ch.fresh_flag),
	.last_of_run   (out_ch.last_of_run)
);
